// ===== rtl/hcbd_pkg.sv =====
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam logic [1:0] ST_PAYLOAD   = 2'd0;
    localparam logic [1:0] ST_FINISHED  = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       starts_body;
    } body_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] status;
    } result_t;

endpackage

// ===== rtl/http_chunked_body_decoder.sv =====
// Decodes an HTTP/1.1 chunked body, one byte per clock unless a held result
// stalls it. Each request on the body channel is registered, run through the
// parser and its result (if any) lands in the result register; a new byte can
// be taken every cycle unless a result waits on result_stall. Size-line
// and chunk-trailer bytes produce no result; payload bytes come out with
// status 0. A zero-size chunk gives status 1 and bad syntax or a size wider
// than SIZE_BITS gives status 2; both repeat for every further byte until a
// byte arrives with starts_body set.
module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    body_valid,
    output logic    body_stall,
    input  body_t   body,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    in_valid_reg;
    body_t   in_data_reg;
    logic    result_valid_reg;
    result_t result_reg;

    logic    produced;
    result_t produced_res;
    logic    out_free;
    logic    advance;

    hcbd_parse #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_data_reg),
        .res_valid (produced),
        .res       (produced_res)
    );

    assign out_free   = !result_valid_reg || !result_stall;
    // bytes that yield no result never wait on the output side
    assign advance    = in_valid_reg && (out_free || !produced);
    assign body_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!body_stall)
        begin
            in_valid_reg <= body_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!body_stall && body_valid)
        begin
            in_data_reg <= body;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && produced)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produced)
        begin
            result_reg <= produced_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/hcbd_parse.sv =====
module hcbd_parse
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  body_t   item,
    output logic    res_valid,
    output result_t res
);

    typedef enum logic [2:0] {
        PH_START,
        PH_HEX,
        PH_EXT,
        PH_DATA,
        PH_TRAIL,
        PH_DONE,
        PH_BAD
    } phase_t;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    phase_t               phase_reg, phase_next, phase_cur;
    logic [SIZE_BITS-1:0] size_reg, size_next, size_cur;
    logic [SIZE_BITS-1:0] left_reg, left_next, left_cur;
    logic                 digits_reg, digits_next, digits_cur;
    logic                 ended_reg, ended_next, ended_cur;
    logic                 cr_reg, cr_next, cr_cur;
    logic [1:0]           trail_reg, trail_next, trail_cur;

    logic [7:0] c;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       do_end;
    logic       do_bad;

    assign c = item.body_byte;

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            hex_val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            hex_val = 4'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            hex_val = 4'(c - 8'h41 + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // starts_body clears the parser before this byte
    always_comb
    begin
        if (item.starts_body)
        begin
            phase_cur  = PH_START;
            size_cur   = '0;
            left_cur   = '0;
            digits_cur = 1'b0;
            ended_cur  = 1'b0;
            cr_cur     = 1'b0;
            trail_cur  = 2'd0;
        end
        else
        begin
            phase_cur  = phase_reg;
            size_cur   = size_reg;
            left_cur   = left_reg;
            digits_cur = digits_reg;
            ended_cur  = ended_reg;
            cr_cur     = cr_reg;
            trail_cur  = trail_reg;
        end
    end

    always_comb
    begin
        phase_next  = phase_cur;
        size_next   = size_cur;
        left_next   = left_cur;
        digits_next = digits_cur;
        ended_next  = ended_cur;
        cr_next     = cr_cur;
        trail_next  = trail_cur;
        res_valid   = 1'b0;
        res.payload_byte = 8'd0;
        res.status       = ST_PAYLOAD;
        do_end = 1'b0;
        do_bad = 1'b0;

        case (phase_cur)
            PH_DONE:
            begin
                res_valid  = 1'b1;
                res.status = ST_FINISHED;
            end
            PH_BAD:
            begin
                res_valid  = 1'b1;
                res.status = ST_MALFORMED;
            end
            PH_DATA:
            begin
                left_next = left_cur - 1'b1;
                if (left_cur == SIZE_BITS'(1))
                begin
                    phase_next = PH_TRAIL;
                    trail_next = 2'd2;
                end
                res_valid        = 1'b1;
                res.payload_byte = c;
            end
            PH_TRAIL:
            begin
                trail_next = trail_cur - 1'b1;
                if (trail_cur == 2'd1)
                begin
                    phase_next  = PH_START;
                    size_next   = '0;
                    digits_next = 1'b0;
                    ended_next  = 1'b0;
                    cr_next     = 1'b0;
                end
            end
            PH_EXT:
            begin
                if (cr_cur && c == CH_LF)
                begin
                    do_end = 1'b1;
                end
                else
                begin
                    cr_next = (c == CH_CR);
                end
            end
            PH_START, PH_HEX:
            begin
                if (cr_cur)
                begin
                    if (c == CH_LF)
                    begin
                        do_end = 1'b1;
                    end
                    else
                    begin
                        do_bad = 1'b1;
                    end
                end
                else if (c == CH_CR)
                begin
                    if (phase_cur == PH_START)
                    begin
                        do_bad = 1'b1;
                    end
                    else
                    begin
                        cr_next = 1'b1;
                    end
                end
                else if (c == CH_SEMI)
                begin
                    if (phase_cur == PH_START)
                    begin
                        do_bad = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_EXT;
                    end
                end
                else
                begin
                    phase_next = PH_HEX;
                    if (c == CH_SPACE || c == CH_TAB)
                    begin
                        if (digits_cur)
                        begin
                            ended_next = 1'b1;
                        end
                    end
                    else if (!is_hex)
                    begin
                        do_bad = 1'b1;
                    end
                    else if (!ended_cur)
                    begin
                        digits_next = 1'b1;
                        // next shift would drop a set bit
                        if (size_cur[SIZE_BITS-1 -: 4] != 4'd0)
                        begin
                            do_bad = 1'b1;
                        end
                        else
                        begin
                            size_next = {size_cur[SIZE_BITS-5:0], hex_val};
                        end
                    end
                end
            end
            default:
            begin
                do_bad = 1'b1;
            end
        endcase

        if (do_end)
        begin
            digits_next = 1'b0;
            ended_next  = 1'b0;
            cr_next     = 1'b0;
            if (size_cur == '0)
            begin
                phase_next = PH_DONE;
                res_valid  = 1'b1;
                res.status = ST_FINISHED;
            end
            else
            begin
                left_next  = size_cur;
                phase_next = PH_DATA;
            end
        end

        if (do_bad)
        begin
            phase_next = PH_BAD;
            res_valid  = 1'b1;
            res.status = ST_MALFORMED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            size_reg   <= '0;
            left_reg   <= '0;
            digits_reg <= 1'b0;
            ended_reg  <= 1'b0;
            cr_reg     <= 1'b0;
            trail_reg  <= 2'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            size_reg   <= size_next;
            left_reg   <= left_next;
            digits_reg <= digits_next;
            ended_reg  <= ended_next;
            cr_reg     <= cr_next;
            trail_reg  <= trail_next;
        end
    end

endmodule
